>>> src/nms_3x3_local_maximum_defines.svh
// assertion macros for the 3x3 non-maximum suppression block
// used by the checker module; expects i_clk and i_rst_n in scope
`ifndef NMS_3X3_LOCAL_MAXIMUM_DEFINES_SVH
`define NMS_3X3_LOCAL_MAXIMUM_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define NMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define NMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/nms_pkg.sv
// shared types, widths and helpers for the 3x3 non-maximum suppression block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nms_pkg;

    // payload widths
    localparam int PIX_W     = 32;
    localparam int ROW_OUT_W = 10;
    localparam int COL_OUT_W = 12;

    // configuration port
    localparam int IMAGE_ROWS_W = 11;
    localparam int IMAGE_COLS_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'b1;

    // reset sizes before clamping
    localparam logic [31:0] IMAGE_ROWS_RST = 32'd1024;
    localparam logic [31:0] IMAGE_COLS_RST = 32'd4096;

    // result of the window compare, handed to the output register
    typedef struct packed {
        logic                        hit;
        logic [ROW_OUT_W-1:0]        row;
        logic [COL_OUT_W-1:0]        col;
        logic signed [PIX_W-1:0]     value;
    } t_hit;

    // saturate a frame size to 3..hi
    function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] res;
        if (v < 32'd3) begin
            res = 32'd3;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/nms_ctl.sv
// frame position counters and size registers for the non-maximum suppression block
// depends on nms_pkg
`timescale 1ns / 1ps
`default_nettype none

module nms_ctl #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [nms_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [nms_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                            i_adv,
    output logic [$clog2(MAX_ROWS)-1:0]          o_row,
    output logic [$clog2(MAX_COLS)-1:0]          o_col
);
    import nms_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int SZR = $clog2(MAX_ROWS + 1);
    localparam int SZC = $clog2(MAX_COLS + 1);
    localparam logic [SZR-1:0] ROWS_RST = SZR'(clamp_size(IMAGE_ROWS_RST, 32'(MAX_ROWS)));
    localparam logic [SZC-1:0] COLS_RST = SZC'(clamp_size(IMAGE_COLS_RST, 32'(MAX_COLS)));

    logic [SZR-1:0] r_rows_sz;
    logic [SZC-1:0] r_cols_sz;
    logic [RW-1:0]  r_row;
    logic [CW-1:0]  r_col;
    logic           row_last;
    logic           col_last;

    // clamped frame size, captured on a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_sz <= ROWS_RST;
            r_cols_sz <= COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_ROWS: r_rows_sz <= SZR'(clamp_size(
                    32'(i_cfg_wdata[IMAGE_ROWS_W-1:0]), 32'(MAX_ROWS)));
                CFG_IMAGE_COLS: r_cols_sz <= SZC'(clamp_size(
                    32'(i_cfg_wdata[IMAGE_COLS_W-1:0]), 32'(MAX_COLS)));
                default: ;
            endcase
        end
    end

    // last row of a column and last column of the frame
    assign row_last = (SZR'(r_row) + SZR'(1)) == r_rows_sz;
    assign col_last = (SZC'(r_col) + SZC'(1)) == r_cols_sz;

    // column-major position; a register write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cfg_we) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_adv) begin
            if (row_last) begin
                r_row <= '0;
                r_col <= col_last ? '0 : r_col + CW'(1);
            end else begin
                r_row <= r_row + RW'(1);
            end
        end
    end

    assign o_row = r_row;
    assign o_col = r_col;

endmodule

`default_nettype wire

>>> src/nms_core.sv
// column stores, 3x3 window and strict-maximum compare
// depends on nms_pkg
`timescale 1ns / 1ps
`default_nettype none

module nms_core #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_fire,
    input  wire logic                              i_s1_fire,
    input  wire logic signed [nms_pkg::PIX_W-1:0]  i_pixel,
    input  wire logic [$clog2(MAX_ROWS)-1:0]       i_row,
    input  wire logic [$clog2(MAX_COLS)-1:0]       i_col,
    output nms_pkg::t_hit                          o_hit
);
    import nms_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    // previous column and the one before it, indexed by row
    logic signed [PIX_W-1:0] r_mem_a [MAX_ROWS];
    logic signed [PIX_W-1:0] r_mem_b [MAX_ROWS];

    // stage register
    logic signed [PIX_W-1:0] r_rd_a;
    logic signed [PIX_W-1:0] r_rd_b;
    logic signed [PIX_W-1:0] r_p1;
    logic [RW-1:0]           r_row1;
    logic [CW-1:0]           r_col1;

    // two rows above the current row in the three active columns
    logic signed [PIX_W-1:0] r_win [6];

    logic signed [PIX_W-1:0] centre;
    logic                    gt_all;
    logic                    interior;
    logic [RW-1:0]           row_m1;
    logic [CW-1:0]           col_m1;

    // store read and stage capture on an input transfer
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_rd_a <= r_mem_a[i_row];
            r_rd_b <= r_mem_b[i_row];
            r_p1   <= i_pixel;
            r_row1 <= i_row;
            r_col1 <= i_col;
        end
    end

    // store write as the item leaves the stage
    always_ff @(posedge i_clk) begin
        if (i_s1_fire) begin
            r_mem_a[r_row1] <= r_p1;
            r_mem_b[r_row1] <= r_rd_a;
        end
    end

    // window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_s1_fire) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_p1;
            r_win[2] <= r_win[3];
            r_win[3] <= r_rd_a;
            r_win[4] <= r_win[5];
            r_win[5] <= r_rd_b;
        end
    end

    // centre against all eight neighbours, ties lose
    assign centre = r_win[3];
    assign gt_all = (centre > r_win[0]) && (centre > r_win[1]) && (centre > r_p1)
                 && (centre > r_win[2]) && (centre > r_rd_a)
                 && (centre > r_win[4]) && (centre > r_win[5]) && (centre > r_rd_b);
    assign interior = (r_row1 >= RW'(2)) && (r_col1 >= CW'(2));
    assign row_m1   = r_row1 - RW'(1);
    assign col_m1   = r_col1 - CW'(1);

    always_comb begin
        o_hit.hit   = interior && gt_all;
        o_hit.row   = ROW_OUT_W'(32'(row_m1));
        o_hit.col   = COL_OUT_W'(32'(col_m1));
        o_hit.value = centre;
    end

endmodule

`default_nettype wire

>>> src/nms_3x3_local_maximum.sv
// top level of the 3x3 non-maximum suppression block: handshakes and output register
// depends on nms_pkg, nms_ctl, nms_core
`timescale 1ns / 1ps
`default_nettype none

// Streams a score map in column-major order, one signed Q16.16 pixel per transfer, and
// reports the row, column and score of every interior pixel strictly greater than its
// eight neighbours. The block sustains one pixel per clock while results are taken: a
// pixel is captured with its two column-store reads, compared against the window, and the
// result lands in the output register as the stage advances, so a maximum is offered once
// its deciding pixel (below and to the right) leaves the stage register. Input ready drops
// only while the stage register is full and the output register holds a result not yet
// taken. Writing image_rows (index 0) or image_cols (index 1) clamps the size to
// 3..MAX_ROWS or 3..MAX_COLS and restarts the frame; write only while the block is idle.
// The column stores are not cleared after reset and need no start-up pass.
module nms_3x3_local_maximum #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [nms_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [nms_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [nms_pkg::PIX_W-1:0]  i_pixel_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [nms_pkg::ROW_OUT_W-1:0]          o_max_row,
    output logic [nms_pkg::COL_OUT_W-1:0]          o_max_col,
    output logic signed [nms_pkg::PIX_W-1:0]       o_max_value
);
    import nms_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    logic          in_fire;
    logic          s1_fire;
    logic          s1_adv;
    logic          r_v1;
    logic          r_out_valid;
    t_hit          hit;
    t_hit          r_out;
    logic [RW-1:0] row;
    logic [CW-1:0] col;

    // handshakes
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign s1_fire    = r_v1 && s1_adv;
    assign o_in_ready = !r_v1 || s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    nms_ctl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (in_fire),
        .o_row       (row),
        .o_col       (col)
    );

    nms_core #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (in_fire),
        .i_s1_fire (s1_fire),
        .i_pixel   (i_pixel_value),
        .i_row     (row),
        .i_col     (col),
        .o_hit     (hit)
    );

    // stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (in_fire) begin
            r_v1 <= 1'b1;
        end else if (s1_fire) begin
            r_v1 <= 1'b0;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= hit.hit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_max_row   = r_out.row;
    assign o_max_col   = r_out.col;
    assign o_max_value = r_out.value;

endmodule

`default_nettype wire

>>> src/nms_chk.sv
// port-level checker for the 3x3 non-maximum suppression block, with its bind
// depends on nms_pkg and nms_3x3_local_maximum_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "nms_3x3_local_maximum_defines.svh"

module nms_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_ready,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [nms_pkg::ROW_OUT_W-1:0]     o_max_row,
    input wire logic [nms_pkg::COL_OUT_W-1:0]     o_max_col,
    input wire logic signed [nms_pkg::PIX_W-1:0]  o_max_value
);

    // a stalled result keeps its valid and its payload
    `NMS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_max_row) && $stable(o_max_col) && $stable(o_max_value), "stalled result changed")

    // with the output register empty the input side never stalls
    `NMS_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready, "input stalled with empty output")

    // under a held output stall only one more pixel fits in the pipeline
    `NMS_ASSERT_NEXT(a_stall_depth, o_out_valid && !i_out_ready && i_in_valid && o_in_ready, !(o_out_valid && !i_out_ready) || !o_in_ready, "pipeline took two pixels under output stall")

endmodule

bind nms_3x3_local_maximum nms_chk u_chk (.*);

`default_nettype wire

>>> bench/nms_3x3_local_maximum_tb.sv
`timescale 1ns / 1ps
// testbench for nms_3x3_local_maximum: directed frames, then random score maps under
// varied idling and backpressure, each maximum checked against the table or a window predictor
// depends on nms_pkg and the block's rtl

module nms_3x3_local_maximum_tb;
    import nms_pkg::*;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLS    = 4096;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic signed [PIX_W-1:0] PIX_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 32'sh8000_0000;
    localparam logic signed [PIX_W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [PIX_W-1:0] NEG_ONE_Q16 = 32'shFFFF_0000;

    typedef struct packed {
        logic [ROW_OUT_W-1:0]    row;
        logic [COL_OUT_W-1:0]    col;
        logic signed [PIX_W-1:0] value;
    } t_peak;

    typedef enum logic [1:0] {
        STEP_SIZE,
        STEP_PIXEL,
        STEP_PIXEL_PEAK,
        STEP_PIXEL_QUIET
    } t_step_kind;

    typedef struct packed {
        t_step_kind              kind;
        logic [CFG_DATA_W-1:0]   rows;
        logic [CFG_DATA_W-1:0]   cols;
        logic signed [PIX_W-1:0] pixel;
        t_peak                   peak;
    } t_step;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata   = '0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_ready;
    logic signed [PIX_W-1:0] i_pixel_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready   = 1'b0;
    logic [ROW_OUT_W-1:0]    o_max_row;
    logic [COL_OUT_W-1:0]    o_max_col;
    logic signed [PIX_W-1:0] o_max_value;

    // maxima still owed by the block, oldest first
    t_peak peaks_due [$];
    int    n_errors        = 0;
    int    send_idle_pct   = 0;
    int    recv_stall_pct  = 0;
    int    hold_off_cycles = 0;

    // predictor state: two stored columns, the 3x3 window, scan position and frame size
    logic signed [PIX_W-1:0] prev_col  [MAX_ROWS];
    logic signed [PIX_W-1:0] prev2_col [MAX_ROWS];
    logic signed [PIX_W-1:0] win [6];
    int unsigned             pos_row;
    int unsigned             pos_col;
    logic [IMAGE_ROWS_W-1:0] rows_reg;
    logic [IMAGE_COLS_W-1:0] cols_reg;

    nms_3x3_local_maximum u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_max_row     (o_max_row),
        .o_max_col     (o_max_col),
        .o_max_value   (o_max_value)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // advance the window by one pixel; returns 1 when the centre is a strict maximum
    function automatic bit window_step(input logic signed [PIX_W-1:0] pix,
                                       output t_peak peak);
        int unsigned             n_rows;
        int unsigned             n_cols;
        int unsigned             slot;
        logic signed [PIX_W-1:0] left1;
        logic signed [PIX_W-1:0] left2;
        logic signed [PIX_W-1:0] centre;
        logic signed [PIX_W-1:0] around [8];
        bit                      found;
        n_rows = (rows_reg < 3) ? 3 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        n_cols = (cols_reg < 3) ? 3 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
        slot   = (pos_row < MAX_ROWS) ? pos_row : 0;
        left1  = prev_col[slot];
        left2  = prev2_col[slot];
        found  = 1'b0;
        peak   = '0;

        // centre sits one row up and one column left of the incoming pixel
        if (pos_row >= 2 && pos_col >= 2) begin
            centre = win[3];
            around = '{win[0], win[1], pix, win[2], left1, win[4], win[5], left2};
            found  = 1'b1;
            foreach (around[k]) begin
                if (!(centre > around[k])) found = 1'b0;
            end
            if (found) begin
                peak.row   = ROW_OUT_W'(pos_row - 1);
                peak.col   = COL_OUT_W'(pos_col - 1);
                peak.value = centre;
            end
        end

        // shift the window and the column stores
        win[0] = win[1];
        win[1] = pix;
        win[2] = win[3];
        win[3] = left1;
        win[4] = win[5];
        win[5] = left2;
        prev2_col[slot] = left1;
        prev_col[slot]  = pix;

        // column-major scan, wrapping at frame end
        pos_row++;
        if (pos_row >= n_rows) begin
            pos_row = 0;
            pos_col++;
            if (pos_col >= n_cols) pos_col = 0;
        end
        return found;
    endfunction

    // mix of full-range words, small values that tie often, extremes and whole Q16.16 steps
    function automatic logic signed [PIX_W-1:0] rand_pixel();
        int unsigned             pick;
        logic signed [PIX_W-1:0] v;
        pick = $urandom_range(99);
        if (pick < 50) begin
            v = $urandom;
        end else if (pick < 75) begin
            v = $urandom_range(6);
            v = v - 3;
        end else if (pick < 85) begin
            v = $urandom_range(1) ? PIX_MAX : PIX_MIN;
        end else begin
            v = $urandom_range(16);
            v = (v - 8) <<< 16;
        end
        return v;
    endfunction

    // offer one pixel, with random idle cycles first, and predict at its transfer
    task automatic send_pixel(input logic signed [PIX_W-1:0] pix, output bit found,
                              output t_peak peak);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_value <= pix;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        found = window_step(pix, peak);
    endtask

    // stop offering, wait for every owed maximum, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (peaks_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write both size registers while idle; either write restarts the frame
    task automatic set_frame_size(input logic [CFG_DATA_W-1:0] rows,
                                  input logic [CFG_DATA_W-1:0] cols);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_IMAGE_ROWS;
        i_cfg_wdata <= rows;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_IMAGE_COLS;
        i_cfg_wdata <= cols;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rows_reg = rows[IMAGE_ROWS_W-1:0];
        cols_reg = cols[IMAGE_COLS_W-1:0];
        pos_row  = 0;
        pos_col  = 0;
    endtask

    // one random stretch at a given frame size and handshake pressure
    task automatic run_phase(input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] cols, input int n_pixels,
                             input int send_pct, input int recv_pct, input int hold);
        bit    found;
        t_peak peak;
        set_frame_size(rows, cols);
        send_idle_pct   = send_pct;
        recv_stall_pct  = recv_pct;
        hold_off_cycles = hold;
        repeat (n_pixels) begin
            send_pixel(rand_pixel(), found, peak);
            if (found) peaks_due.push_back(peak);
        end
    endtask

    // result side ready: a long hold-off when requested, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each result transfer with the oldest owed maximum
    always @(posedge i_clk) begin : result_check
        t_peak want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (peaks_due.size() == 0) begin
                $error("unexpected maximum: row %0d col %0d value %0d",
                       o_max_row, o_max_col, o_max_value);
                n_errors++;
            end else begin
                want = peaks_due.pop_front();
                if (o_max_row !== want.row) begin
                    $error("max_row expected %0d, got %0d", want.row, o_max_row);
                    n_errors++;
                end
                if (o_max_col !== want.col) begin
                    $error("max_col expected %0d, got %0d", want.col, o_max_col);
                    n_errors++;
                end
                if (o_max_value !== want.value) begin
                    $error("max_value expected %0d, got %0d", want.value, o_max_value);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on total run length
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // main sequence
    initial begin : stimulus
        t_step plan [$];
        bit    found;
        t_peak peak;

        // predictor matches the block after reset
        foreach (prev_col[i]) begin
            prev_col[i]  = '0;
            prev2_col[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        pos_row  = 0;
        pos_col  = 0;
        rows_reg = IMAGE_ROWS_RST[IMAGE_ROWS_W-1:0];
        cols_reg = IMAGE_COLS_RST[IMAGE_COLS_W-1:0];

        // sizes below range clamp to a 3x3 frame
        plan.push_back(t_step'{STEP_SIZE, 13'd0, 13'd2, '0, '0});
        // top score surrounded by the lowest: signed compare must win
        repeat (4) plan.push_back(t_step'{STEP_PIXEL, '0, '0, PIX_MIN, '0});
        plan.push_back(t_step'{STEP_PIXEL, '0, '0, PIX_MAX, '0});
        repeat (3) plan.push_back(t_step'{STEP_PIXEL, '0, '0, PIX_MIN, '0});
        plan.push_back(t_step'{STEP_PIXEL_PEAK, '0, '0, PIX_MIN,
                               t_peak'{10'd1, 12'd1, PIX_MAX}});
        // next frame after the wrap: one step above the lowest score
        repeat (4) plan.push_back(t_step'{STEP_PIXEL, '0, '0, PIX_MIN, '0});
        plan.push_back(t_step'{STEP_PIXEL, '0, '0, PIX_MIN + 1, '0});
        repeat (3) plan.push_back(t_step'{STEP_PIXEL, '0, '0, PIX_MIN, '0});
        plan.push_back(t_step'{STEP_PIXEL_PEAK, '0, '0, PIX_MIN,
                               t_peak'{10'd1, 12'd1, PIX_MIN + 1}});
        // restart, then a tie with the lower-right neighbour is no maximum
        plan.push_back(t_step'{STEP_SIZE, 13'd3, 13'd3, '0, '0});
        repeat (4) plan.push_back(t_step'{STEP_PIXEL, '0, '0, NEG_ONE_Q16, '0});
        plan.push_back(t_step'{STEP_PIXEL, '0, '0, ONE_Q16, '0});
        repeat (3) plan.push_back(t_step'{STEP_PIXEL, '0, '0, NEG_ONE_Q16, '0});
        plan.push_back(t_step'{STEP_PIXEL_QUIET, '0, '0, ONE_Q16, '0});

        // reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (plan[i]) begin
            case (plan[i].kind)
                STEP_SIZE: begin
                    set_frame_size(plan[i].rows, plan[i].cols);
                end
                STEP_PIXEL: begin
                    send_pixel(plan[i].pixel, found, peak);
                    if (found) peaks_due.push_back(peak);
                end
                STEP_PIXEL_PEAK: begin
                    send_pixel(plan[i].pixel, found, peak);
                    peaks_due.push_back(plan[i].peak);
                end
                default: begin
                    send_pixel(plan[i].pixel, found, peak);
                end
            endcase
        end

        // random maps: small frames under each idling pattern
        run_phase($urandom_range(3, 12), $urandom_range(3, 12), 300, 0, 0, 0);
        run_phase($urandom_range(3, 12), $urandom_range(3, 12), 300, 87, 0, 0);
        run_phase($urandom_range(3, 12), $urandom_range(3, 12), 300, 0, 87, 0);
        run_phase($urandom_range(3, 12), $urandom_range(3, 12), 300, 25, 25, 0);
        // long receiver hold-off so the block fills and stalls its input
        run_phase(13'd8, 13'd8, 150, 0, 0, 400);
        // large sizes: high bits dropped and clamped, then exact top values
        run_phase(13'h1FFF, 13'd4096, 50, 0, 0, 0);
        run_phase(13'd1024, 13'h1FFF, 50, 0, 25, 0);
        // sizes below range again, under mixed idling
        run_phase(13'd1, 13'd0, 100, 25, 25, 0);

        settle();
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
